// ----- design/perceptron_branch_predictor_top_assert.svh -----
// assertion macros used by the predictor's controller
// expects clk and rst (synchronous, active high) in the including module
`ifndef PERCEPTRON_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define PBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pbp_pkg.sv -----
// shared types and constants of the perceptron branch predictor
// no dependencies; imported by controller, datapath, row reduction unit and top level
`default_nettype none

package pbp_pkg;

  // item function codes
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_TRAIN   = 1'b1;

  // training threshold register
  localparam int unsigned THRESH_W = 12;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd68;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mod_a;
    logic mod_b;
    logic mod_c;
    logic mem_rd;
    logic sum_a;
    logic sum_b;
    logic train_wr;
    logic clear;
    logic out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_train;
    logic clear_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/pbp_rowmod.sv -----
// row select unit: pc mod ROWS by reciprocal multiply and one correction
// depends on pbp_pkg (command struct)
`default_nettype none

module pbp_rowmod #(
  parameter int unsigned ROWS  = 141,
  parameter int unsigned ROW_W = 8
) (
  input  wire logic              clk,
  input  wire pbp_pkg::dp_cmd_t  cmd,
  input  wire logic [31:0]       pc_q,
  output logic      [ROW_W-1:0]  row
);
  import pbp_pkg::*;

  // floor(2^32 / ROWS); quotient estimate is low by at most one
  localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / ROWS);
  localparam logic [31:0] ROWS_C = 32'(ROWS);

  logic [64:0] prod;
  logic [31:0] q_est;
  logic [31:0] q_times;
  logic [31:0] rem_raw;
  logic [31:0] rem_fix;

  assign prod    = 65'(pc_q) * 65'(RECIP);
  assign rem_raw = pc_q - q_times;
  assign rem_fix = (rem_raw >= ROWS_C) ? (rem_raw - ROWS_C) : rem_raw;

  // three registered steps: estimate, back-multiply, subtract and correct
  always_ff @(posedge clk) begin
    if (cmd.mod_a) begin
      q_est <= prod[63:32];
    end
    if (cmd.mod_b) begin
      q_times <= 32'(q_est * ROWS_C);
    end
    if (cmd.mod_c) begin
      row <= ROW_W'(rem_fix);
    end
  end

endmodule

`default_nettype wire

// ----- design/pbp_dp.sv -----
// datapath: perceptron table memory, dot product tree, training update,
// history, remembered prediction, threshold register and result register
// depends on pbp_pkg and pbp_rowmod
`default_nettype none

module pbp_dp #(
  parameter int unsigned ROWS        = 141,
  parameter int unsigned HISTORY_LEN = 28,
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pbp_pkg::dp_cmd_t               cmd,
  output pbp_pkg::dp_status_t                 status,
  input  wire logic                           func,
  input  wire logic [31:0]                    pc,
  input  wire logic                           outcome,
  input  wire logic                           cfg_we,
  input  wire logic [pbp_pkg::THRESH_W-1:0]   cfg_data,
  output logic                                taken,
  output logic                                weights_updated
);
  import pbp_pkg::*;

  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned TERMS  = HISTORY_LEN + 1;
  localparam int unsigned WORD_W = TERMS * WEIGHT_BITS;
  localparam int unsigned SUM_W  = WEIGHT_BITS + $clog2(TERMS) + 2;
  localparam int unsigned GROUP  = 8;
  localparam int unsigned GROUPS = (TERMS + GROUP - 1) / GROUP;
  localparam int unsigned CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] WMIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [WEIGHT_BITS-1:0] WONE = WEIGHT_BITS'(1);

  // one row per word: bias in slot 0, weight i in slot i+1
  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] mem_q;
  logic [WORD_W-1:0] upd_word;
  logic [WORD_W-1:0] wr_data;
  logic [ROW_W-1:0]  wr_addr;
  logic [ROW_W-1:0]  rd_addr;
  logic              wr_en;

  // captured item
  logic        is_train;
  logic [31:0] pc_q;
  logic        oc_q;

  // model state
  logic [HISTORY_LEN-1:0]   hist;
  logic [HISTORY_LEN:0]     hist_shift;
  logic [ROW_W-1:0]         last_row;
  logic signed [SUM_W-1:0]  last_sum;
  logic                     last_taken;
  logic [THRESH_W-1:0]      thresh;
  logic [ROW_W-1:0]         clr_cnt;

  // dot product tree
  logic [ROW_W-1:0]         row;
  logic [TERMS-1:0]         plus;
  logic signed [SUM_W-1:0]  term     [TERMS];
  logic signed [SUM_W-1:0]  part_c   [GROUPS];
  logic signed [SUM_W-1:0]  part     [GROUPS];
  logic signed [SUM_W-1:0]  sum_c;

  // training decision
  logic [SUM_W-1:0]         mag;
  logic                     upd;
  logic [TERMS-1:0]         up;

  // result payload
  logic res_taken;
  logic res_upd;

  pbp_rowmod #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_rowmod (
    .clk  (clk),
    .cmd  (cmd),
    .pc_q (pc_q),
    .row  (row)
  );

  assign status.is_train   = is_train;
  assign status.clear_done = (clr_cnt == ROW_LAST);

  // signed terms: bias always added, weight negated on a zero history bit
  assign plus = {hist, 1'b1};

  always_comb begin
    for (int k = 0; k < TERMS; k++) begin
      if (plus[k]) begin
        term[k] = SUM_W'($signed(mem_q[k*WEIGHT_BITS +: WEIGHT_BITS]));
      end else begin
        term[k] = -SUM_W'($signed(mem_q[k*WEIGHT_BITS +: WEIGHT_BITS]));
      end
    end
  end

  // first tree level: groups of eight terms
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_c[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < TERMS) begin
          part_c[g] = part_c[g] + term[g*GROUP + j];
        end
      end
    end
  end

  // second tree level: the group partials
  always_comb begin
    sum_c = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_c = sum_c + part[g];
    end
  end

  // train when mispredicted or not confident enough
  assign mag = last_sum[SUM_W-1] ? SUM_W'(-last_sum) : SUM_W'(last_sum);
  assign upd = (oc_q != last_taken) || (CMP_W'(mag) <= CMP_W'(thresh));

  // per slot direction: bias follows outcome, weight follows agreement
  assign up = {~(hist ^ {HISTORY_LEN{oc_q}}), oc_q};

  always_comb begin
    for (int k = 0; k < TERMS; k++) begin
      if (up[k]) begin
        upd_word[k*WEIGHT_BITS +: WEIGHT_BITS] =
          (mem_q[k*WEIGHT_BITS +: WEIGHT_BITS] == WMAX) ? WMAX
          : mem_q[k*WEIGHT_BITS +: WEIGHT_BITS] + WONE;
      end else begin
        upd_word[k*WEIGHT_BITS +: WEIGHT_BITS] =
          (mem_q[k*WEIGHT_BITS +: WEIGHT_BITS] == WMIN) ? WMIN
          : mem_q[k*WEIGHT_BITS +: WEIGHT_BITS] - WONE;
      end
    end
  end

  // memory port selection
  assign rd_addr    = is_train ? last_row : row;
  assign wr_en      = cmd.clear || (cmd.train_wr && upd);
  assign wr_addr    = cmd.clear ? clr_cnt : last_row;
  assign wr_data    = cmd.clear ? '0 : upd_word;
  assign hist_shift = {hist, oc_q};

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_train <= (func == FUNC_TRAIN);
      pc_q     <= pc;
      oc_q     <= outcome;
    end
    if (cmd.sum_a) begin
      for (int g = 0; g < GROUPS; g++) begin
        part[g] <= part_c[g];
      end
    end
    if (cmd.sum_b) begin
      res_taken <= ~sum_c[SUM_W-1];
      res_upd   <= 1'b0;
    end
    if (cmd.train_wr) begin
      res_taken <= 1'b0;
      res_upd   <= upd;
    end
    if (cmd.out_load) begin
      taken           <= res_taken;
      weights_updated <= res_upd;
    end
  end

  // architectural state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      hist       <= '0;
      last_row   <= '0;
      last_sum   <= '0;
      last_taken <= 1'b0;
      thresh     <= THRESH_RESET;
      clr_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        thresh <= cfg_data;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + ROW_W'(1);
      end
      if (cmd.sum_b) begin
        last_row   <= row;
        last_sum   <= sum_c;
        last_taken <= ~sum_c[SUM_W-1];
      end
      if (cmd.train_wr) begin
        hist <= hist_shift[HISTORY_LEN-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pbp_ctrl.sv -----
// controller: sequences the clearing pass, predict and train items, and
// owns the result valid; depends on pbp_pkg and the assertion macro header
`default_nettype none
`include "perceptron_branch_predictor_top_assert.svh"

module pbp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 func,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pbp_pkg::dp_cmd_t          cmd,
  input  wire pbp_pkg::dp_status_t  status
);
  import pbp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD_A,
    S_MOD_B,
    S_MOD_C,
    S_RD,
    S_SUM_A,
    S_SUM_B,
    S_UPD,
    S_OUT
  } state_t;

  state_t state;
  logic   in_beat;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // commands decoded from the state and the handshake signals
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_beat;
    cmd.clear    = (state == S_CLEAR);
    cmd.mod_a    = (state == S_MOD_A);
    cmd.mod_b    = (state == S_MOD_B);
    cmd.mod_c    = (state == S_MOD_C);
    cmd.mem_rd   = (state == S_RD);
    cmd.sum_a    = (state == S_SUM_A);
    cmd.sum_b    = (state == S_SUM_B);
    cmd.train_wr = (state == S_UPD);
    cmd.out_load = (state == S_OUT) && out_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (status.clear_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= (func == FUNC_TRAIN) ? S_RD : S_MOD_A;
          end
        end
        S_MOD_A: state <= S_MOD_B;
        S_MOD_B: state <= S_MOD_C;
        S_MOD_C: state <= S_RD;
        S_RD: begin
          state <= status.is_train ? S_UPD : S_SUM_A;
        end
        S_SUM_A: state <= S_SUM_B;
        S_SUM_B: state <= S_OUT;
        S_UPD:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a train beat goes straight to the row read
  `PBP_ASSERT_NEXT(a_train_reads, in_beat && (func == FUNC_TRAIN), state == S_RD, "train beat did not start a row read")
  // a predict beat reads its row after the three reduction steps
  `PBP_ASSERT_SAME(a_pred_reads, in_beat && (func == FUNC_PREDICT), ##4 cmd.mem_rd, "predict beat did not read its row in time")
  // table writes, reads and captures never overlap
  `PBP_ASSERT_SAME(a_cmd_excl, 1'b1, $onehot0({cmd.capture, cmd.mem_rd, cmd.train_wr, cmd.clear}), "overlapping datapath commands")
  // the clearing pass ends in idle once the last row is written
  `PBP_ASSERT_NEXT(a_clear_end, (state == S_CLEAR) && status.clear_done, state == S_IDLE, "clearing pass did not finish")

endmodule

`default_nettype wire

// ----- design/perceptron_branch_predictor_top.sv -----
// Perceptron branch predictor. After reset the block runs a clearing pass over all ROWS table rows
// (one table row per cycle) before it takes its first input beat; threshold writes are
// accepted at any time. Items are handled one at a time: a predict beat passes from
// acceptance to result through pc mod ROWS reduction by a reciprocal multiplier, one
// registered row read, two adder tree levels and the output register load, and a train
// beat through row read, update and write back, and output. The next beat is accepted
// while a result still waits in the output register.
// top level: joins the controller and the datapath; depends on pbp_pkg, pbp_ctrl and pbp_dp
`default_nettype none

module perceptron_branch_predictor_top #(
  parameter int unsigned ROWS        = 141,
  parameter int unsigned HISTORY_LEN = 28,
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          func,
  input  wire logic [31:0]                   pc,
  input  wire logic                          outcome,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               taken,
  output logic                               weights_updated,
  input  wire logic                          cfg_we,
  input  wire logic [pbp_pkg::THRESH_W-1:0]  cfg_data
);
  import pbp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  pbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // table, arithmetic and state
  pbp_dp #(
    .ROWS        (ROWS),
    .HISTORY_LEN (HISTORY_LEN),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .func            (func),
    .pc              (pc),
    .outcome         (outcome),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .taken           (taken),
    .weights_updated (weights_updated)
  );

endmodule

`default_nettype wire
